// ----- rtl/rfp_pkg.sv -----
// Package for the response frame parser: field widths, status and kind codes,
// register indexes and frame constants. No dependencies.
package rfp_pkg;

   localparam int BYTE_W   = 8;
   localparam int STATUS_W = 2;
   localparam int ADDR_W   = 3;
   localparam int DATA_W   = 32;

   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [STATUS_W-1:0] status_type;

   // result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // end-of-frame status codes
   localparam status_type STAT_OK      = 2'd0;
   localparam status_type STAT_INVALID = 2'd1;
   localparam status_type STAT_NOSPACE = 2'd2;

   // register indexes (paddr[2])
   localparam logic REG_EXP_CMD  = 1'b0;
   localparam logic REG_CAPACITY = 1'b1;

   // frame constants
   localparam byte_type PREAMBLE    = 8'h00;
   localparam byte_type START_CODE1 = 8'h00;
   localparam byte_type START_CODE2 = 8'hFF;
   localparam byte_type DIR_TO_HOST = 8'hD5;

   localparam byte_type CMD_RESET_VAL = 8'd0;
   localparam byte_type CAP_RESET_VAL = 8'd255;

endpackage

// ----- rtl/rfp_req_if.sv -----
// Input channel of the response frame parser: one received byte per transfer.
// Depends on rfp_pkg.
interface rfp_req_if;
   import rfp_pkg::*;

   logic     valid;
   logic     ready;
   byte_type rx_byte;
   logic     frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

// ----- rtl/rfp_rsp_if.sv -----
// Result channel of the response frame parser: payload bytes and end status.
// Depends on rfp_pkg.
interface rfp_rsp_if;
   import rfp_pkg::*;

   logic       valid;
   logic       ready;
   logic       result_kind;
   byte_type   payload_byte;
   status_type frame_status;
   byte_type   payload_length;
   logic       is_last;

   modport source (output valid, output result_kind, output payload_byte,
                   output frame_status, output payload_length, output is_last,
                   input ready);
   modport sink   (input valid, input result_kind, input payload_byte,
                   input frame_status, input payload_length, input is_last,
                   output ready);
endinterface

// ----- rtl/response_frame_parser.sv -----
// Response frame parser top level: input register, per-byte frame checker and
// result register. Depends on rfp_pkg, rfp_req_if and rfp_rsp_if.
//
// Takes one received byte per transfer (frame_start marks the preamble) and
// checks preamble, start codes, length checksum, direction byte D5, command
// (expected_command + 1) and data checksum, passing payload bytes out one per
// result and closing each frame with one end result (ok, invalid or no space).
// A byte is taken into an input register and checked from there; its result
// (if any) is then held in the result register. Sustained rate is one byte per
// clock; the only thing that slows it is the result register waiting on rsp
// ready. Registers: expected_command at address 0, payload_capacity at address
// 4, written by the user only while idle; the block does not enforce this.
module response_frame_parser (
   input  logic                        clock,
   input  logic                        reset,
   rfp_req_if.sink                     req_ch,
   rfp_rsp_if.source                   rsp_ch,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [rfp_pkg::ADDR_W-1:0]  paddr,
   input  logic [rfp_pkg::DATA_W-1:0]  pwdata,
   output logic [rfp_pkg::DATA_W-1:0]  prdata,
   output logic                        pready
);
   import rfp_pkg::*;

   // parse phases
   localparam logic [3:0] PH_PRE  = 4'd0;
   localparam logic [3:0] PH_SC1  = 4'd1;
   localparam logic [3:0] PH_SC2  = 4'd2;
   localparam logic [3:0] PH_LEN  = 4'd3;
   localparam logic [3:0] PH_LCS  = 4'd4;
   localparam logic [3:0] PH_TFI  = 4'd5;
   localparam logic [3:0] PH_CMD  = 4'd6;
   localparam logic [3:0] PH_DATA = 4'd7;
   localparam logic [3:0] PH_DCS  = 4'd8;
   localparam logic [3:0] PH_POST = 4'd9;
   localparam logic [3:0] PH_DONE = 4'd10;

   // configuration registers
   byte_type   exp_cmd_ff, exp_cmd_in;
   byte_type   cap_ff, cap_in;

   // input register
   logic       in_vld_ff, in_vld_in;
   byte_type   in_byte_ff, in_byte_in;
   logic       in_start_ff, in_start_in;

   // parser state
   logic [3:0] phase_ff, phase_in;
   byte_type   len_ff, len_in;
   byte_type   rem_ff, rem_in;
   byte_type   sum_ff, sum_in;
   logic       ovf_ff, ovf_in;

   // result register
   logic       out_vld_ff, out_vld_in;
   logic       out_kind_ff, out_kind_in;
   byte_type   out_byte_ff, out_byte_in;
   status_type out_stat_ff, out_stat_in;
   byte_type   out_len_ff, out_len_in;
   logic       out_last_ff, out_last_in;

   logic       advance;
   logic       cfg_wr;
   logic [3:0] ph_cur;
   byte_type   len_cur, rem_cur, sum_cur, cmd, count, rem_dec;
   logic       ovf_cur;
   logic       res_vld;

   // input register frees when its byte moves on
   assign advance      = in_vld_ff && (!out_vld_ff || rsp_ch.ready);
   assign req_ch.ready = !in_vld_ff || advance;

   always_comb begin
      in_vld_in   = in_vld_ff;
      in_byte_in  = in_byte_ff;
      in_start_in = in_start_ff;
      if (req_ch.ready) begin
         in_vld_in   = req_ch.valid;
         in_byte_in  = req_ch.rx_byte;
         in_start_in = req_ch.frame_start;
      end
   end

   // configuration port
   assign pready = 1'b1;
   assign cfg_wr = psel && penable && pwrite;
   assign prdata = (paddr[2] == REG_CAPACITY) ? {{(DATA_W-BYTE_W){1'b0}}, cap_ff}
                                              : {{(DATA_W-BYTE_W){1'b0}}, exp_cmd_ff};

   always_comb begin
      exp_cmd_in = exp_cmd_ff;
      cap_in     = cap_ff;
      if (cfg_wr) begin
         case (paddr[2])
            REG_EXP_CMD:  exp_cmd_in = pwdata[BYTE_W-1:0];
            REG_CAPACITY: cap_in     = pwdata[BYTE_W-1:0];
            default: ;
         endcase
      end
   end

   // frame start restarts the parser whatever its phase
   assign ph_cur  = in_start_ff ? PH_PRE : phase_ff;
   assign len_cur = in_start_ff ? '0 : len_ff;
   assign rem_cur = in_start_ff ? '0 : rem_ff;
   assign sum_cur = in_start_ff ? '0 : sum_ff;
   assign ovf_cur = in_start_ff ? 1'b0 : ovf_ff;
   assign cmd     = exp_cmd_ff + 8'd1;
   assign count   = len_cur - 8'd2;
   assign rem_dec = rem_cur - 8'd1;

   // per-byte check and state update
   always_comb begin
      phase_in    = ph_cur;
      len_in      = len_cur;
      rem_in      = rem_cur;
      sum_in      = sum_cur;
      ovf_in      = ovf_cur;
      res_vld     = 1'b0;
      out_kind_in = KIND_END;
      out_byte_in = '0;
      out_stat_in = STAT_INVALID;
      out_len_in  = '0;
      out_last_in = 1'b1;
      case (ph_cur)
         PH_PRE: begin
            if (in_byte_ff != PREAMBLE) res_vld = 1'b1;
            else phase_in = PH_SC1;
         end
         PH_SC1: begin
            if (in_byte_ff != START_CODE1) res_vld = 1'b1;
            else phase_in = PH_SC2;
         end
         PH_SC2: begin
            if (in_byte_ff != START_CODE2) res_vld = 1'b1;
            else phase_in = PH_LEN;
         end
         PH_LEN: begin
            len_in   = in_byte_ff;
            phase_in = PH_LCS;
         end
         PH_LCS: begin
            if (byte_type'(len_cur + in_byte_ff) != 8'd0) res_vld = 1'b1;
            else phase_in = PH_TFI;
         end
         PH_TFI: begin
            if (in_byte_ff != DIR_TO_HOST) res_vld = 1'b1;
            else phase_in = PH_CMD;
         end
         PH_CMD: begin
            if (in_byte_ff != cmd) begin
               res_vld = 1'b1;
            end else begin
               ovf_in   = (count > cap_ff);
               rem_in   = count;
               sum_in   = DIR_TO_HOST + cmd;
               phase_in = (count == 8'd0) ? PH_DCS : PH_DATA;
            end
         end
         PH_DATA: begin
            rem_in = rem_dec;
            if (rem_dec == 8'd0) phase_in = PH_DCS;
            if (!ovf_cur) begin
               sum_in      = sum_cur + in_byte_ff;
               res_vld     = 1'b1;
               out_kind_in = KIND_PAYLOAD;
               out_byte_in = in_byte_ff;
               out_stat_in = STAT_OK;
               out_last_in = 1'b0;
            end
         end
         PH_DCS: begin
            if (!ovf_cur && byte_type'(sum_cur + in_byte_ff) != 8'd0) res_vld = 1'b1;
            else phase_in = PH_POST;
         end
         PH_POST: begin
            res_vld = 1'b1;
            if (ovf_cur) begin
               out_stat_in = STAT_NOSPACE;
            end else begin
               out_stat_in = STAT_OK;
               out_len_in  = count;
            end
         end
         default: phase_in = PH_DONE;
      endcase
      // every end result leaves the parser idle
      if (res_vld && out_last_in) phase_in = PH_DONE;
   end

   assign out_vld_in = advance ? res_vld : (out_vld_ff && !rsp_ch.ready);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         exp_cmd_ff <= CMD_RESET_VAL;
         cap_ff     <= CAP_RESET_VAL;
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
         phase_ff   <= PH_DONE;
         len_ff     <= '0;
         rem_ff     <= '0;
         sum_ff     <= '0;
         ovf_ff     <= 1'b0;
      end else begin
         exp_cmd_ff <= exp_cmd_in;
         cap_ff     <= cap_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
         if (advance) begin
            phase_ff <= phase_in;
            len_ff   <= len_in;
            rem_ff   <= rem_in;
            sum_ff   <= sum_in;
            ovf_ff   <= ovf_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_start_ff <= in_start_in;
      if (advance) begin
         out_kind_ff <= out_kind_in;
         out_byte_ff <= out_byte_in;
         out_stat_ff <= out_stat_in;
         out_len_ff  <= out_len_in;
         out_last_ff <= out_last_in;
      end
   end

   assign rsp_ch.valid          = out_vld_ff;
   assign rsp_ch.result_kind    = out_kind_ff;
   assign rsp_ch.payload_byte   = out_byte_ff;
   assign rsp_ch.frame_status   = out_stat_ff;
   assign rsp_ch.payload_length = out_len_ff;
   assign rsp_ch.is_last        = out_last_ff;

   // payload results carry the ok status and never close a frame
   a_payload_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.result_kind == KIND_PAYLOAD
         |-> rsp_ch.frame_status == STAT_OK && !rsp_ch.is_last)
      else $error("payload result with end fields set");

   // the data phase always has bytes left to take
   a_data_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DATA |-> rem_ff != 8'd0)
      else $error("data phase with zero bytes remaining");

   // an ok end reports the LEN byte minus two as length and leaves the parser idle
   a_ok_length: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.is_last && rsp_ch.frame_status == STAT_OK
         |-> rsp_ch.payload_length == byte_type'(len_ff - 8'd2) && phase_ff == PH_DONE)
      else $error("ok end length does not match frame length");

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for response_frame_parser: directed and random response frames
// checked against a behavioral frame tracker, with random idling on both channels.
// Depends on rfp_pkg, rfp_req_if, rfp_rsp_if and the response_frame_parser RTL.
module tb_top;
   import rfp_pkg::*;

   // parser position inside a frame
   typedef enum logic [3:0] {
      AT_PREAMBLE, AT_START1, AT_START2, AT_LENGTH, AT_LENGTH_SUM, AT_DIRECTION,
      AT_COMMAND, AT_PAYLOAD, AT_DATA_SUM, AT_POSTAMBLE, AT_IDLE
   } frame_pos_type;

   typedef struct packed {
      logic       kind;
      byte_type   data;
      status_type status;
      byte_type   length;
      logic       last;
   } parser_result_type;

   logic clock;
   logic reset;
   logic psel;
   logic penable;
   logic pwrite;
   logic [ADDR_W-1:0] paddr;
   logic [DATA_W-1:0] pwdata;
   logic [DATA_W-1:0] prdata;
   logic pready;

   rfp_req_if req_bus ();
   rfp_rsp_if rsp_bus ();

   response_frame_parser dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_bus),
      .rsp_ch  (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // frame tracker state and register copies
   frame_pos_type frame_pos = AT_IDLE;
   byte_type   frame_len = 8'd0;
   byte_type   remaining = 8'd0;
   byte_type   data_sum = 8'd0;
   logic       discarding = 1'b0;
   byte_type   cfg_command = CMD_RESET_VAL;
   byte_type   cfg_capacity = CAP_RESET_VAL;

   parser_result_type expected_results[$];
   parser_result_type want_result;
   byte_type       frame_bytes[$];
   int             error_count = 0;
   int             burst_left = 0;
   int             frame_bytes_sent = 0;
   int             rx_cycle = 0;
   int             rx_mode = 0;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // hard stop in case the block hangs
   initial begin
      #5000000;
      $display("tb_top failed");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      error_count++;
      if (error_count <= 200)
         $display("%0t: %s mismatch, got %0h expected %0h", $realtime, what, got, want);
   endtask

   task automatic close_frame(input status_type status, input byte_type length);
      parser_result_type r;
      r.kind = KIND_END;
      r.data = 8'd0;
      r.status = status;
      r.length = length;
      r.last = 1'b1;
      expected_results.push_back(r);
      frame_pos = AT_IDLE;
   endtask

   // advance the tracker by one accepted byte, queuing any result it causes
   task automatic track_frame_byte(input byte_type value, input logic start);
      byte_type resp_cmd;
      byte_type count;
      byte_type sum8;
      parser_result_type r;
      resp_cmd = cfg_command + 8'd1;
      if (start) begin
         frame_pos = AT_PREAMBLE;
         frame_len = 8'd0;
         remaining = 8'd0;
         data_sum = 8'd0;
         discarding = 1'b0;
      end
      case (frame_pos)
         AT_PREAMBLE: begin
            if (value != PREAMBLE) close_frame(STAT_INVALID, 8'd0);
            else frame_pos = AT_START1;
         end
         AT_START1: begin
            if (value != START_CODE1) close_frame(STAT_INVALID, 8'd0);
            else frame_pos = AT_START2;
         end
         AT_START2: begin
            if (value != START_CODE2) close_frame(STAT_INVALID, 8'd0);
            else frame_pos = AT_LENGTH;
         end
         AT_LENGTH: begin
            frame_len = value;
            frame_pos = AT_LENGTH_SUM;
         end
         AT_LENGTH_SUM: begin
            sum8 = frame_len + value;
            if (sum8 != 8'd0) close_frame(STAT_INVALID, 8'd0);
            else frame_pos = AT_DIRECTION;
         end
         AT_DIRECTION: begin
            if (value != DIR_TO_HOST) close_frame(STAT_INVALID, 8'd0);
            else frame_pos = AT_COMMAND;
         end
         AT_COMMAND: begin
            if (value != resp_cmd) begin
               close_frame(STAT_INVALID, 8'd0);
            end else begin
               count = frame_len - 8'd2;
               discarding = (count > cfg_capacity);
               remaining = count;
               data_sum = DIR_TO_HOST + resp_cmd;
               frame_pos = (count == 8'd0) ? AT_DATA_SUM : AT_PAYLOAD;
            end
         end
         AT_PAYLOAD: begin
            remaining = remaining - 8'd1;
            if (remaining == 8'd0) frame_pos = AT_DATA_SUM;
            if (!discarding) begin
               data_sum = data_sum + value;
               r.kind = KIND_PAYLOAD;
               r.data = value;
               r.status = STAT_OK;
               r.length = 8'd0;
               r.last = 1'b0;
               expected_results.push_back(r);
            end
         end
         AT_DATA_SUM: begin
            sum8 = data_sum + value;
            if (!discarding && sum8 != 8'd0) close_frame(STAT_INVALID, 8'd0);
            else frame_pos = AT_POSTAMBLE;
         end
         AT_POSTAMBLE: begin
            if (discarding) close_frame(STAT_NOSPACE, 8'd0);
            else close_frame(STAT_OK, frame_len - 8'd2);
         end
         default: frame_pos = AT_IDLE;
      endcase
   endtask

   // one byte transfer; the sender runs in bursts separated by random gaps
   task automatic send_byte(input byte_type value, input logic start);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 10) : $urandom_range(0, 2);
         burst_left = ($urandom_range(0, 7) == 0) ? 80 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_bus.valid <= 1'b1;
      req_bus.rx_byte <= value;
      req_bus.frame_start <= start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      track_frame_byte(value, start);
      burst_left--;
   endtask

   // well-formed frame with n payload bytes for the current command setting
   task automatic build_frame(input int n, input bit extremes);
      byte_type len;
      byte_type cmd;
      byte_type sum;
      byte_type d;
      frame_bytes = {};
      len = byte_type'(n + 2);
      cmd = cfg_command + 8'd1;
      frame_bytes.push_back(PREAMBLE);
      frame_bytes.push_back(START_CODE1);
      frame_bytes.push_back(START_CODE2);
      frame_bytes.push_back(len);
      frame_bytes.push_back(8'd0 - len);
      frame_bytes.push_back(DIR_TO_HOST);
      frame_bytes.push_back(cmd);
      sum = DIR_TO_HOST + cmd;
      for (int i = 0; i < n; i++) begin
         if (extremes) d = i[0] ? 8'hFF : 8'h00;
         else d = byte_type'($urandom_range(0, 255));
         frame_bytes.push_back(d);
         sum = sum + d;
      end
      frame_bytes.push_back(8'd0 - sum);
      frame_bytes.push_back(byte_type'($urandom_range(0, 255)));
   endtask

   task automatic corrupt_byte(input int idx);
      frame_bytes[idx] = frame_bytes[idx] ^ byte_type'($urandom_range(1, 255));
   endtask

   // first k bytes of the built frame, the first one flagged as frame start
   task automatic send_frame(input int k);
      for (int i = 0; i < k; i++) send_byte(frame_bytes[i], i == 0);
      frame_bytes_sent += k;
   endtask

   // stop sending, wait for every pending result, then let the pipeline empty
   task automatic drain_results();
      int waited;
      waited = 0;
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0 && waited < 20000) begin
         @(posedge clock);
         waited++;
      end
      if (expected_results.size() != 0) begin
         report_mismatch("results still pending", 0, expected_results.size());
         expected_results = {};
      end
      repeat (8) @(posedge clock);
   endtask

   // APB write followed by a read back of the same register
   task automatic csr_write(input logic reg_index, input byte_type value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {reg_index, 2'b00};
      pwdata <= DATA_W'(value);
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (reg_index == REG_EXP_CMD) cfg_command = value;
      else cfg_capacity = value;
      penable <= 1'b0;
      pwrite <= 1'b0;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      if (prdata !== DATA_W'(value)) report_mismatch("register read back", prdata, value);
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   // bytes outside a frame are dropped without a result
   task automatic test_idle_bytes();
      send_byte(8'hA5, 1'b0);
      send_byte(8'h00, 1'b0);
   endtask

   // reset register values: alternating 00/FF payload, then an empty payload
   task automatic test_good_frames();
      build_frame(2, 1'b1);
      send_frame(frame_bytes.size());
      build_frame(0, 1'b0);
      send_frame(frame_bytes.size());
   endtask

   // each header check failing on its own byte, frame cut right after it
   task automatic test_header_checks();
      int positions[6] = '{0, 1, 2, 4, 5, 6};
      foreach (positions[i]) begin
         build_frame(0, 1'b0);
         corrupt_byte(positions[i]);
         send_frame(positions[i] + 1);
      end
   endtask

   // bad payload byte: invalid on the checksum byte, postamble then dropped
   task automatic test_checksum_fail();
      build_frame(3, 1'b0);
      corrupt_byte(7);
      send_frame(frame_bytes.size());
   endtask

   // frame start in the middle of a payload restarts the parser
   task automatic test_restart();
      build_frame(4, 1'b0);
      send_frame(9);
      build_frame(1, 1'b0);
      send_frame(frame_bytes.size());
   endtask

   // payload over capacity is discarded, its checksum left unchecked
   task automatic test_no_space();
      drain_results();
      csr_write(REG_EXP_CMD, 8'hFF);
      csr_write(REG_CAPACITY, 8'd1);
      build_frame(2, 1'b0);
      corrupt_byte(9);
      send_frame(frame_bytes.size());
      build_frame(1, 1'b0);
      send_frame(frame_bytes.size());
      build_frame(0, 1'b0);
      send_frame(frame_bytes.size());
   endtask

   // length bytes 1 and 0 wrap to payload counts of 255 and 254
   task automatic test_large_frames();
      drain_results();
      csr_write(REG_CAPACITY, 8'hFF);
      build_frame(255, 1'b0);
      send_frame(frame_bytes.size());
      drain_results();
      csr_write(REG_CAPACITY, 8'd253);
      build_frame(254, 1'b0);
      send_frame(frame_bytes.size());
   endtask

   // mostly clean frames, some corrupted, cut short or preceded by stray bytes
   task automatic send_random_frame();
      int r;
      int n;
      int size;
      r = $urandom_range(0, 99);
      n = $urandom_range(0, 99);
      if (n < 70) n = $urandom_range(0, 6);
      else if (n < 95) n = $urandom_range(7, 24);
      else n = $urandom_range(25, 60);
      build_frame(n, 1'b0);
      size = frame_bytes.size();
      if (r < 65) begin
         send_frame(size);
      end else if (r < 80) begin
         corrupt_byte($urandom_range(0, size - 2));
         send_frame(size);
      end else if (r < 90) begin
         send_frame($urandom_range(1, size - 1));
      end else begin
         repeat ($urandom_range(1, 3)) send_byte(byte_type'($urandom_range(0, 255)), 1'b0);
         send_frame(size);
      end
   endtask

   task automatic test_random_traffic();
      byte_type cmd;
      byte_type cap;
      int phase_start;
      for (int p = 0; p < 6; p++) begin
         case (p)
            0: begin cmd = 8'h00; cap = 8'hFF; end
            1: begin cmd = 8'hFF; cap = 8'h00; end
            2: begin cmd = 8'h80; cap = 8'd4; end
            3: begin
               cmd = byte_type'($urandom_range(0, 255));
               cap = byte_type'($urandom_range(0, 10));
            end
            4: begin cmd = byte_type'($urandom_range(0, 255)); cap = 8'hFF; end
            default: begin cmd = 8'h01; cap = byte_type'($urandom_range(0, 30)); end
         endcase
         drain_results();
         csr_write(REG_EXP_CMD, cmd);
         csr_write(REG_CAPACITY, cap);
         phase_start = frame_bytes_sent;
         while (frame_bytes_sent - phase_start < 45) send_random_frame();
      end
   endtask

   // result-side ready follows one of four patterns, each picked at random
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         rx_cycle++;
         if (rx_cycle % 64 == 0) rx_mode = $urandom_range(0, 3);
         case (rx_mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= 1'($urandom_range(0, 1));
            2: rsp_bus.ready <= (rx_cycle % 5 != 0);
            default: rsp_bus.ready <= (rx_cycle % 16 < 4);
         endcase
      end
   end

   // compare each result transfer with the oldest pending expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (expected_results.size() == 0) begin
            report_mismatch("result with none pending", rsp_bus.result_kind, 0);
         end else begin
            want_result = expected_results.pop_front();
            if (rsp_bus.result_kind !== want_result.kind)
               report_mismatch("result_kind", rsp_bus.result_kind, want_result.kind);
            if (rsp_bus.payload_byte !== want_result.data)
               report_mismatch("payload_byte", rsp_bus.payload_byte, want_result.data);
            if (rsp_bus.frame_status !== want_result.status)
               report_mismatch("frame_status", rsp_bus.frame_status, want_result.status);
            if (rsp_bus.payload_length !== want_result.length)
               report_mismatch("payload_length", rsp_bus.payload_length, want_result.length);
            if (rsp_bus.is_last !== want_result.last)
               report_mismatch("is_last", rsp_bus.is_last, want_result.last);
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.rx_byte = 8'd0;
      req_bus.frame_start = 1'b0;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_idle_bytes();
      test_good_frames();
      test_header_checks();
      test_checksum_fail();
      test_restart();
      test_no_space();
      test_large_frames();
      test_random_traffic();
      drain_results();
      repeat (10) @(posedge clock);
      if (error_count == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

endmodule
